### rtl/wsd_pkg.sv
// Package for the WebSocket frame deframer: frame phases, result kinds,
// opcodes and the result record types shared by the parser, output stage and top.
// No dependencies.
package wsd_pkg;

    // Frame parsing phases, one-hot coded.
    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_PAY  = 5'b10000
    } t_phase;

    // Result kinds.
    localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
    localparam logic [2:0] KIND_FINAL      = 3'd1;
    localparam logic [2:0] KIND_FRAGMENT   = 3'd2;
    localparam logic [2:0] KIND_CLOSE      = 3'd3;
    localparam logic [2:0] KIND_INCOMPLETE = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN_OP = 3'd5;
    localparam logic [2:0] KIND_NOT_WS     = 3'd6;

    // Opcodes and header field codes.
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // Remaining-byte counts, stored as count minus one.
    localparam logic [2:0] EXT16_LEFT = 3'd1;
    localparam logic [2:0] EXT64_LEFT = 3'd7;
    localparam logic [2:0] KEY_LEFT   = 3'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [63:0] payload_length;
        logic        is_text;
    } t_result;

    // Results caused by one input byte, in emission order.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

    function automatic t_result simple_result(input logic [2:0] kind);
        t_result r;
        r.kind           = kind;
        r.data_byte      = 8'd0;
        r.payload_length = 64'd0;
        r.is_text        = 1'b0;
        return r;
    endfunction

    // Completion result at the end of a frame.
    function automatic t_result complete_result(input logic [3:0] opcode, input logic fin,
                                                input logic [63:0] len);
        t_result r;
        r.data_byte      = 8'd0;
        r.payload_length = len;
        r.is_text        = 1'b0;
        if (opcode == OP_CLOSE) begin
            r.kind = KIND_CLOSE;
        end else if (opcode == OP_TEXT || opcode == OP_BINARY) begin
            r.kind    = fin ? KIND_FINAL : KIND_FRAGMENT;
            r.is_text = (opcode == OP_TEXT);
        end else begin
            r.kind = KIND_UNKNOWN_OP;
        end
        return r;
    endfunction

endpackage

### rtl/wsd_parser.sv
// Frame header parser and payload unmasker for the WebSocket frame deframer.
// Holds the frame state; computes the results of one byte combinationally.
// Depends on wsd_pkg.
module wsd_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_byte,
    input  logic            i_end,
    output wsd_pkg::t_step  o_step
);

    wsd_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_ext_cnt, n_ext_cnt;
    logic            r_fin, n_fin;
    logic [3:0]      r_opcode, n_opcode;
    logic [63:0]     r_len, n_len;
    logic [31:0]     r_key, n_key;
    logic [63:0]     r_pay_cnt, n_pay_cnt;
    logic            r_skip, n_skip;

    logic            decided;
    logic            ra_v, rb_v;
    wsd_pkg::t_result ra, rb;
    logic [7:0]      key_byte;
    logic            is_data_op;

    always_comb begin
        n_phase    = r_phase;
        n_ext_cnt  = r_ext_cnt;
        n_fin      = r_fin;
        n_opcode   = r_opcode;
        n_len      = r_len;
        n_key      = r_key;
        n_pay_cnt  = r_pay_cnt;
        n_skip     = r_skip;
        decided    = 1'b0;
        ra_v       = 1'b0;
        rb_v       = 1'b0;
        ra         = wsd_pkg::simple_result(wsd_pkg::KIND_NOT_WS);
        rb         = wsd_pkg::simple_result(wsd_pkg::KIND_INCOMPLETE);
        is_data_op = (r_opcode == wsd_pkg::OP_TEXT) || (r_opcode == wsd_pkg::OP_BINARY);
        unique case (r_pay_cnt[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase

        if (r_skip) begin
            if (i_end) begin
                n_skip  = 1'b0;
                n_phase = wsd_pkg::PH_HDR0;
            end
        end else begin
            unique case (r_phase)
                wsd_pkg::PH_HDR1: begin
                    if (!i_byte[7]) begin
                        ra_v    = 1'b1;
                        decided = 1'b1;
                    end else if (i_byte[6:0] == wsd_pkg::LEN_CODE_16) begin
                        n_ext_cnt = wsd_pkg::EXT16_LEFT;
                        n_phase   = wsd_pkg::PH_EXT;
                    end else if (i_byte[6:0] == wsd_pkg::LEN_CODE_64) begin
                        n_ext_cnt = wsd_pkg::EXT64_LEFT;
                        n_phase   = wsd_pkg::PH_EXT;
                    end else begin
                        n_len     = {57'd0, i_byte[6:0]};
                        n_ext_cnt = wsd_pkg::KEY_LEFT;
                        n_phase   = wsd_pkg::PH_KEY;
                    end
                end
                wsd_pkg::PH_EXT: begin
                    n_len = {r_len[55:0], i_byte};
                    if (r_ext_cnt == 3'd0) begin
                        n_ext_cnt = wsd_pkg::KEY_LEFT;
                        n_phase   = wsd_pkg::PH_KEY;
                    end else begin
                        n_ext_cnt = r_ext_cnt - 3'd1;
                    end
                end
                wsd_pkg::PH_KEY: begin
                    n_key = {r_key[23:0], i_byte};
                    if (r_ext_cnt == 3'd0) begin
                        n_phase = wsd_pkg::PH_PAY;
                        // An empty payload completes on the last key byte.
                        if (r_len == 64'd0) begin
                            ra_v    = 1'b1;
                            ra      = wsd_pkg::complete_result(r_opcode, r_fin, r_len);
                            decided = 1'b1;
                        end
                    end else begin
                        n_ext_cnt = r_ext_cnt - 3'd1;
                    end
                end
                wsd_pkg::PH_PAY: begin
                    if (is_data_op) begin
                        ra_v         = 1'b1;
                        ra.kind      = wsd_pkg::KIND_PAYLOAD;
                        ra.data_byte = i_byte ^ key_byte;
                        ra.is_text   = (r_opcode == wsd_pkg::OP_TEXT);
                    end
                    n_pay_cnt = r_pay_cnt + 64'd1;
                    if (n_pay_cnt == r_len) begin
                        rb_v    = 1'b1;
                        rb      = wsd_pkg::complete_result(r_opcode, r_fin, r_len);
                        decided = 1'b1;
                    end
                end
                default: begin
                    n_fin     = i_byte[7];
                    n_opcode  = i_byte[3:0];
                    n_len     = 64'd0;
                    n_key     = 32'd0;
                    n_pay_cnt = 64'd0;
                    n_ext_cnt = 3'd0;
                    if (i_end) begin
                        ra_v    = 1'b1;
                        decided = 1'b1;
                    end else begin
                        n_phase = wsd_pkg::PH_HDR1;
                    end
                end
            endcase

            if (decided) begin
                n_phase = wsd_pkg::PH_HDR0;
                n_skip  = !i_end;
            end else if (i_end) begin
                rb_v    = 1'b1;
                rb      = wsd_pkg::simple_result(wsd_pkg::KIND_INCOMPLETE);
                n_phase = wsd_pkg::PH_HDR0;
            end
        end

        o_step.count = {1'b0, ra_v} + {1'b0, rb_v};
        o_step.res0  = ra_v ? ra : rb;
        o_step.res1  = rb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= wsd_pkg::PH_HDR0;
            r_ext_cnt <= 3'd0;
            r_fin     <= 1'b0;
            r_opcode  <= 4'd0;
            r_len     <= 64'd0;
            r_key     <= 32'd0;
            r_pay_cnt <= 64'd0;
            r_skip    <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_ext_cnt <= n_ext_cnt;
            r_fin     <= n_fin;
            r_opcode  <= n_opcode;
            r_len     <= n_len;
            r_key     <= n_key;
            r_pay_cnt <= n_pay_cnt;
            r_skip    <= n_skip;
        end
    end

endmodule

### rtl/wsd_out.sv
// Result register of the WebSocket frame deframer: holds the up to two
// results of one byte and hands them out one per transaction. Depends on wsd_pkg.
module wsd_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  wsd_pkg::t_step    i_step,
    input  logic              i_tready,
    output logic              o_can_load,
    output logic              o_tvalid,
    output wsd_pkg::t_result  o_result,
    output logic              o_last
);

    logic [1:0]       r_cnt, n_cnt;
    logic             r_head, n_head;
    wsd_pkg::t_result r_res0, r_res1;
    logic             pop;

    assign o_tvalid   = (r_cnt != 2'd0);
    assign pop        = o_tvalid && i_tready;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_tready);
    assign o_result   = r_head ? r_res1 : r_res0;
    assign o_last     = (r_cnt == 2'd1);

    always_comb begin
        n_cnt  = r_cnt;
        n_head = r_head;
        if (i_load) begin
            n_cnt  = i_step.count;
            n_head = 1'b0;
        end else if (pop) begin
            n_cnt  = r_cnt - 2'd1;
            n_head = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res0 <= i_step.res0;
            r_res1 <= i_step.res1;
        end
    end

endmodule

### rtl/websocket_frame_deframer.sv
// WebSocket frame deframer, top level; depends on wsd_pkg, wsd_parser and wsd_out.
// A byte accepted at the input passes through the input register and then the result
// register before its first result reaches the output port.
// Throughput: one byte per cycle while the output is not stalled; a byte that causes
// two results holds the output for two transactions, drained one per cycle on tready.
// Reset: synchronous, active low; the parser returns to expecting a first header byte.
module websocket_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream: one byte of the received buffer per transaction.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic        i_s_axis_tlast,   // buffer_end
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [7:0] data_byte, [71:8] payload_length
    output logic [3:0]  o_m_axis_tuser,   // [2:0] kind, [3] is_text
    output logic        o_m_axis_tlast    // last_of_run
);

    // Input register. It is refilled in the same cycle that its byte is
    // processed, so a steady stream goes through at one byte per cycle when the output keeps up.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    logic             in_accept;
    logic             fire;
    logic             out_load;
    logic             can_load;
    wsd_pkg::t_step   step;
    wsd_pkg::t_result out_res;

    // A byte is processed when its results fit in the result register; a byte
    // with no results never waits on the output side.
    assign fire            = r_in_valid && (can_load || (step.count == 2'd0));
    assign out_load        = fire && (step.count != 2'd0);
    assign o_s_axis_tready = !r_in_valid || fire;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tlast;
        end
    end

    // Header parsing, key collection and unmasking of the byte held in the
    // input register. Frame state advances only when the byte is processed.
    wsd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_step  (step)
    );

    // Result register: the payload byte comes first, then any completion or
    // discard result of the same input byte.
    wsd_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (out_load),
        .i_step     (step),
        .i_tready   (i_m_axis_tready),
        .o_can_load (can_load),
        .o_tvalid   (o_m_axis_tvalid),
        .o_result   (out_res),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {out_res.payload_length, out_res.data_byte};
    assign o_m_axis_tuser = {out_res.is_text, out_res.kind};

endmodule
